>>> rtl/tks_pkg.sv
// shared types and constants for the top-k sorted insertion block
package tks_pkg;

	localparam int DATA_W         = 32;
	localparam int KEEP_COUNT_DEF = 64;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_READOUT = 1'b1
	} op_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;   // insert the broadcast value
		logic rot;   // rotate the chain one place upward
	} cell_ctrl_t;

endpackage

>>> rtl/top_k_sorted_insert_top.sv
// top level of the top-k sorted insertion block
//
// Keeps the KEEP_COUNT largest signed values seen, in a chain of cells sorted
// ascending (cell 0 holds the minimum, every cell resets to zero). On an insert
// request every cell compares its value with the offered value in parallel and
// either takes its upper neighbor's value, takes the new value, or holds, so
// inserts can be accepted back to back at one per cycle while no readout is
// running. A value not strictly above the current minimum is dropped; among
// equal values the newcomer lands above the ones already held. A readout
// request holds the request side from the accepting cycle until one rotation
// per slot is done. The chain rotates one place upward per cycle whenever the
// output register is free or being drained, the top cell feeds the output
// register, and after KEEP_COUNT rotations the store is back in its original
// order. in_stall is high for the whole readout; the final (smallest) value
// carries last.
module top_k_sorted_insert_top import tks_pkg::*; #(
	parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// request channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [DATA_W-1:0] value,
	// result channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     last
);

	localparam int CNT_W = $clog2(KEEP_COUNT);

	logic signed [DATA_W-1:0] slot_w [KEEP_COUNT];
	logic                     le_w   [KEEP_COUNT];

	logic                     busy_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic                     last_q;

	logic       in_acc;
	logic       ins;
	logic       start;
	logic       out_load;
	logic       last_step;
	cell_ctrl_t ctrl;

	// request side: readout blocks new requests until the last value is loaded
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !in_stall;
	// an insert only reaches the cells when it beats the current minimum
	assign ins      = in_acc && (op_t'(op) == OP_INSERT) && (value > slot_w[0]);
	assign start    = in_acc && (op_t'(op) == OP_READOUT);

	// readout advances whenever the output register is free or being drained
	assign out_load  = busy_q && (!out_valid_q || !out_stall);
	assign last_step = (cnt_q == CNT_W'(KEEP_COUNT - 1));

	assign ctrl.ins = ins;
	assign ctrl.rot = out_load;

	// chain of compare cells; cell 0 rotates in the top value on readout
	for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
		logic signed [DATA_W-1:0] up_val;
		logic                     up_le;
		logic signed [DATA_W-1:0] lo_val;

		if (i == KEEP_COUNT - 1) begin : g_top
			assign up_val = '0;
			assign up_le  = 1'b0;
		end else begin : g_mid
			assign up_val = slot_w[i+1];
			assign up_le  = le_w[i+1];
		end

		if (i == 0) begin : g_bot
			assign lo_val = slot_w[KEEP_COUNT-1];
		end else begin : g_up
			assign lo_val = slot_w[i-1];
		end

		tks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (value),
			.take_floor (i == 0),
			.upper_val  (up_val),
			.upper_le   (up_le),
			.lower_val  (lo_val),
			.slot_val   (slot_w[i]),
			.slot_le    (le_w[i])
		);
	end

	// readout sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_load) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= slot_w[KEEP_COUNT-1];
			last_q      <= last_step;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	// the two lowest cells stay in order whenever no readout is in progress
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (slot_w[0] <= slot_w[1]))
		else $error("slot chain out of order");

	// an insert never lowers the minimum
	a_min_rises: assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> (slot_w[0] >= $past(slot_w[0])))
		else $error("insert lowered the minimum");

	// the final rotation ends the readout
	a_readout_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_step) |=> !busy_q)
		else $error("readout ran past the last slot");

	// inserts and rotation never coincide
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.rot))
		else $error("insert during readout");

endmodule

>>> rtl/tks_cell.sv
// one slot of the sorted chain: compare against the broadcast value and shift
module tks_cell import tks_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     take_floor,
	input  logic signed [DATA_W-1:0] upper_val,
	input  logic                     upper_le,
	input  logic signed [DATA_W-1:0] lower_val,
	output logic signed [DATA_W-1:0] slot_val,
	output logic                     slot_le
);

	logic signed [DATA_W-1:0] slot_q;

	assign slot_val = slot_q;
	assign slot_le  = (slot_q <= value);

	// slot contents are state with a defined reset of zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.rot) begin
			slot_q <= lower_val;
		end else if (ctrl.ins) begin
			if (upper_le) begin
				slot_q <= upper_val;
			end else if (slot_le || take_floor) begin
				slot_q <= value;
			end
		end
	end

endmodule
